>>> sv/gba_pkg.sv
// Shared types and constants of the grouped bitmap block allocator.
`timescale 1ns / 1ps
package gba_pkg;
	localparam int OPCODE_W    = 2;
	localparam int BLOCK_W     = 14;
	localparam int GROUP_SEL_W = 3;
	localparam int STATUS_W    = 2;
	localparam int BPG_W       = 11;
	localparam int GCOUNT_W    = 4;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [OPCODE_W-1:0] OP_FIND  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

	localparam logic REG_BPG    = 1'b0;
	localparam logic REG_GCOUNT = 1'b1;

	localparam logic [BPG_W-1:0]    BPG_RESET    = 11'd1024;
	localparam logic [GCOUNT_W-1:0] GCOUNT_RESET = 4'd8;

	// Effective configuration after rounding and saturation.
	typedef struct packed {
		logic [BPG_W-1:0]    bpg;
		logic [GCOUNT_W-1:0] ng;
	} cfg_t;
endpackage

>>> sv/gba_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface gba_req_if;
	logic                             valid;
	logic                             ready;
	logic [gba_pkg::OPCODE_W-1:0]     opcode;
	logic [gba_pkg::BLOCK_W-1:0]      block_number;
	logic [gba_pkg::GROUP_SEL_W-1:0]  start_group;

	modport source (output valid, output opcode, output block_number, output start_group,
		input ready);
	modport sink (input valid, input opcode, input block_number, input start_group,
		output ready);
endinterface

interface gba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gba_pkg::STATUS_W-1:0]  status;
	logic [gba_pkg::BLOCK_W-1:0]   found_block;

	modport source (output valid, output status, output found_block, input ready);
	modport sink (input valid, input status, input found_block, output ready);
endinterface

>>> sv/gba_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module gba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> sv/gba_cfg.sv
// APB configuration registers and their effective, saturated values.
`timescale 1ns / 1ps
module gba_cfg #(
	parameter int MAX_GROUPS     = 8,
	parameter int MAX_GROUP_BITS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gba_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [gba_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [gba_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output gba_pkg::cfg_t                     eff
);
	import gba_pkg::*;

	localparam int BPG_CAP = (MAX_GROUP_BITS / 8) * 8;

	logic [BPG_W-1:0]    bpg_q;
	logic [GCOUNT_W-1:0] gc_q;
	logic [BPG_W-1:0]    bpg_m8;
	logic                reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpg_q <= BPG_RESET;
			gc_q  <= GCOUNT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_BPG:    bpg_q <= pwdata[BPG_W-1:0];
				REG_GCOUNT: gc_q  <= pwdata[GCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BPG:    prdata = APB_DATA_W'(bpg_q);
			REG_GCOUNT: prdata = APB_DATA_W'(gc_q);
			default:    prdata = '0;
		endcase
	end

	// Round the group size down to whole bytes and keep both values in range.
	assign bpg_m8 = {bpg_q[BPG_W-1:3], 3'b000};

	always_comb begin
		if (bpg_m8 < BPG_W'(8)) begin
			eff.bpg = BPG_W'(8);
		end else if (32'(bpg_m8) > BPG_CAP) begin
			eff.bpg = BPG_W'(BPG_CAP);
		end else begin
			eff.bpg = bpg_m8;
		end
		if (gc_q == '0) begin
			eff.ng = GCOUNT_W'(1);
		end else if (32'(gc_q) > MAX_GROUPS) begin
			eff.ng = GCOUNT_W'(MAX_GROUPS);
		end else begin
			eff.ng = gc_q;
		end
	end
endmodule

>>> sv/grouped_bitmap_block_allocator.sv
// Top level of the grouped bitmap block allocator: control sequencer and bitmap store.
`timescale 1ns / 1ps
// The allocator keeps a free-block bitmap of MAX_GROUPS groups, each of up to
// MAX_GROUP_BITS bits, in a byte-wide single-port RAM; a set bit marks a block as
// allocated. After reset the block sweeps the RAM to zero, one byte per cycle;
// requests are held off until the sweep is done, while APB writes are taken at any
// time. A request is one transfer on req and yields exactly one transfer on rsp. One
// request is in work at a time; a finished result sits in an output register so a
// stalled rsp does not block the next request. Find reads one bitmap byte per cycle
// through a registered read pipeline, starting at start_group and wrapping, and stops
// at the first byte that is not all ones. Mark allocated and mark free split the block
// number into group and index by repeated subtraction of the group size, one group
// per cycle, then read, modify and write the byte. Configuration should only be
// written while no request is in work.
module grouped_bitmap_block_allocator #(
	parameter int MAX_GROUPS     = 8,
	parameter int MAX_GROUP_BITS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gba_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [gba_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [gba_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	gba_req_if.sink                           req,
	gba_rsp_if.source                         rsp
);
	import gba_pkg::*;

	localparam int GROUP_BYTES = MAX_GROUP_BITS / 8;
	localparam int MAP_BYTES   = MAX_GROUPS * GROUP_BYTES;
	localparam int AW          = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	// Sequencer states.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_SUM   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_MOD   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	cfg_t eff;

	logic [2:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic [OPCODE_W-1:0] op_q;

	// Find: issue side of the read pipeline.
	logic [3:0] ig_q;
	logic [7:0] ib_q;
	logic [3:0] cnt_q;
	logic       issuing_q;
	// Find: read in flight, its data arrives in the following cycle.
	logic       v_s1;
	logic [3:0] g_s1;
	logic [7:0] b_s1;
	// Find: hit position and block base.
	logic [3:0]  fg_q;
	logic [10:0] fidx_q;
	logic [14:0] prod_q;

	// Marks: remainder and group of the split block number.
	logic [BLOCK_W-1:0] rem_q;
	logic [3:0]         mg_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [BLOCK_W-1:0]  res_found_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [BLOCK_W-1:0]  rsp_found_q;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic [7:0]    mark_mask;
	logic [7:0]    nbytes;
	logic          byte_full;
	logic [2:0]    zpos;
	logic          zseen;

	function automatic logic [AW-1:0] grp_addr(input logic [3:0] g, input logic [7:0] b);
		return AW'(32'(g) * GROUP_BYTES + 32'(b));
	endfunction

	gba_cfg #(
		.MAX_GROUPS     (MAX_GROUPS),
		.MAX_GROUP_BITS (MAX_GROUP_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.eff     (eff)
	);

	gba_ram #(
		.WIDTH (8),
		.DEPTH (MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.found_block = rsp_found_q;

	assign nbytes    = eff.bpg[BPG_W-1:3];
	assign byte_full = (mem_rdata == 8'hFF);
	// Bit i of a group sits at weight 7-(i%8), so index bit 0 is the MSB.
	assign mark_mask = 8'h80 >> rem_q[2:0];

	// Lowest-weight clear bit of the returned byte.
	always_comb begin
		zpos  = 3'd0;
		zseen = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!zseen && !mem_rdata[i]) begin
				zpos  = 3'(i);
				zseen = 1'b1;
			end
		end
	end

	// RAM port: clear sweep, scan reads, and the read-modify-write of a mark.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = 8'h00;
		mem_addr  = grp_addr(ig_q, ib_q);
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_DIV: begin
				mem_addr = grp_addr(mg_q, rem_q[10:3]);
			end
			S_MOD: begin
				mem_we    = 1'b1;
				mem_addr  = grp_addr(mg_q, rem_q[10:3]);
				mem_wdata = (op_q == OP_ALLOC) ? (mem_rdata | mark_mask)
				                               : (mem_rdata & ~mark_mask);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			op_q         <= OP_FIND;
			ig_q         <= '0;
			ib_q         <= '0;
			cnt_q        <= '0;
			issuing_q    <= 1'b0;
			v_s1         <= 1'b0;
			g_s1         <= '0;
			b_s1         <= '0;
			fg_q         <= '0;
			fidx_q       <= '0;
			prod_q       <= '0;
			rem_q        <= '0;
			mg_q         <= '0;
			res_status_q <= ST_DONE;
			res_found_q  <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_found_q  <= '0;
		end else begin
			// The output register empties on a transfer unless a new result refills it.
			if (rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q        <= req.opcode;
						res_found_q <= '0;
						unique case (req.opcode) inside
							OP_FIND: begin
								if ({1'b0, req.start_group} >= eff.ng) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_DONE;
									ig_q         <= {1'b0, req.start_group};
									ib_q         <= '0;
									cnt_q        <= '0;
									issuing_q    <= 1'b1;
									v_s1         <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							OP_ALLOC, OP_FREE: begin
								if (req.block_number == '0) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_DONE;
									rem_q        <= req.block_number - BLOCK_W'(1);
									mg_q         <= '0;
									state_q      <= S_DIV;
								end
							end
							default: begin
								res_status_q <= ST_DONE;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (v_s1 && !byte_full) begin
						fg_q      <= g_s1;
						fidx_q    <= {b_s1, ~zpos};
						v_s1      <= 1'b0;
						issuing_q <= 1'b0;
						state_q   <= S_MUL;
					end else if (v_s1 && !issuing_q) begin
						// The last byte of the last group came back full.
						v_s1         <= 1'b0;
						res_status_q <= ST_NO_FREE;
						state_q      <= S_DONE;
					end else begin
						v_s1 <= issuing_q;
						g_s1 <= ig_q;
						b_s1 <= ib_q;
						if (issuing_q) begin
							if (ib_q == nbytes - 8'd1) begin
								ib_q  <= '0;
								ig_q  <= (ig_q == eff.ng - 4'd1) ? 4'd0 : ig_q + 4'd1;
								cnt_q <= cnt_q + 4'd1;
								if (cnt_q == eff.ng - 4'd1) begin
									issuing_q <= 1'b0;
								end
							end else begin
								ib_q <= ib_q + 8'd1;
							end
						end
					end
				end
				S_MUL: begin
					prod_q  <= 15'(fg_q) * 15'(eff.bpg);
					state_q <= S_SUM;
				end
				S_SUM: begin
					res_found_q <= BLOCK_W'(16'(prod_q) + 16'(fidx_q) + 16'd1);
					state_q     <= S_DONE;
				end
				S_DIV: begin
					if (rem_q < BLOCK_W'(eff.bpg)) begin
						// The byte read is issued in this cycle.
						state_q <= S_MOD;
					end else if (mg_q == eff.ng - 4'd1) begin
						res_status_q <= ST_RANGE;
						state_q      <= S_DONE;
					end else begin
						rem_q <= rem_q - BLOCK_W'(eff.bpg);
						mg_q  <= mg_q + 4'd1;
					end
				end
				S_MOD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_found_q  <= res_found_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> sv/gba_checker.sv
// Port-level checker for the grouped bitmap block allocator, bound to the top level.
`timescale 1ns / 1ps
module gba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [gba_pkg::STATUS_W-1:0]  rsp_status,
	input logic [gba_pkg::BLOCK_W-1:0]   rsp_found
);
	import gba_pkg::*;

	// A stalled result transfer keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found))
		else $error("result changed while stalled");

	// Only the three defined status codes are ever reported.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_NO_FREE ||
		               rsp_status == ST_RANGE))
		else $error("undefined status code");

	// A block number is only returned with a successful status.
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_DONE |-> rsp_found == '0)
		else $error("block number reported with a failing status");

	// One request at a time: the request side closes right after a transfer.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in work");
endmodule

bind grouped_bitmap_block_allocator gba_checker u_gba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_found  (rsp.found_block)
);
